### hw/rtl/dpls_pkg.sv
// shared types, constants and pattern helper functions for the dash line splitter
package dpls_pkg;

	localparam int COORD_W = 24;
	localparam int CFG_W = 24;
	localparam int LEN_W = 25;
	localparam int PERIOD_W = 27;
	localparam int QUOT_W = 25;
	localparam int PROD_W = PERIOD_W + QUOT_W;
	localparam int CFG_IDX_W = 3;
	localparam int PATTERN_PAIRS_DEF = 3;
	localparam int MAX_SEGMENTS_DEF = 64;

	localparam logic [LEN_W-1:0] LEN_ONE = 25'd64;
	localparam logic [CFG_W-1:0] LEN_RESET = 24'd640;

	localparam logic [1:0] CMD_MOVE = 2'd0;
	localparam logic [1:0] CMD_LINE = 2'd1;
	localparam logic [1:0] CMD_CLOSE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DASH_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DASH_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_B = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DASH_C = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_C = 3'd6;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_MOVE,
		OP_LINE_INIT,
		OP_TOTAL,
		OP_EMIT_TAIL,
		OP_SHORT_END,
		OP_TAIL_END,
		OP_SKIP_DIV,
		OP_MUL_KP,
		OP_SKIP_APPLY,
		OP_SET_ND,
		OP_MUL_INTERP,
		OP_DIV_INTERP,
		OP_STORE,
		OP_EMIT_CUT,
		OP_CUT_APPLY,
		OP_TAKE_N,
		OP_DRAIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic use_start;
		logic axis_y;
	} dp_cmd_t;

	typedef struct packed {
		logic short_line;
		logic loop_go;
		logic skip_ok;
		logic div_busy;
		logic drain_done;
	} dp_stat_t;

	typedef logic [2:0][CFG_W-1:0] len_tab_t;

	function automatic logic [1:0] pairs_used(logic [1:0] cnt, int pairs);
		logic [1:0] c;
		c = cnt;
		if (c == 2'd0) c = 2'd1;
		if (int'(c) > pairs) c = 2'(pairs);
		return c;
	endfunction

	function automatic logic [CFG_W-1:0] dash_of(logic [1:0] idx, len_tab_t tab, int pairs);
		logic [CFG_W-1:0] v;
		v = tab[0];
		if (int'(idx) < pairs && idx != 2'd3) v = tab[idx];
		if (v == '0) v = CFG_W'(1);
		return v;
	endfunction

	function automatic logic [CFG_W-1:0] gap_of(logic [1:0] idx, len_tab_t tab, int pairs);
		logic [CFG_W-1:0] v;
		v = tab[0];
		if (int'(idx) < pairs && idx != 2'd3) v = tab[idx];
		return v;
	endfunction

	// (idx + 1) mod used, used is 1..3
	function automatic logic [1:0] next_index(logic [1:0] idx, logic [1:0] used);
		logic [2:0] v;
		v = {1'b0, idx} + 3'd1;
		for (int i = 0; i < 4; i++) begin
			if (v >= {1'b0, used}) v = v - {1'b0, used};
		end
		return v[1:0];
	endfunction

	function automatic logic [PERIOD_W-1:0] period_len(logic [1:0] cnt, len_tab_t dash,
			len_tab_t gap, int pairs);
		logic [PERIOD_W-1:0] s;
		logic [1:0] used;
		s = '0;
		used = pairs_used(cnt, pairs);
		for (int i = 0; i < 3; i++) begin
			if (i < int'(used)) begin
				s = s + PERIOD_W'(dash_of(2'(i), dash, pairs)) + PERIOD_W'(gap_of(2'(i), gap, pairs));
			end
		end
		return s;
	endfunction

endpackage

### hw/rtl/dpls_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit QUOT_W bits
module dpls_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dpls_pkg::PROD_W-1:0]    dividend,
	input  logic [dpls_pkg::PERIOD_W-1:0]  divisor,
	output logic                           busy,
	output logic [dpls_pkg::QUOT_W-1:0]    quotient
);

	localparam int QW = dpls_pkg::QUOT_W;
	localparam int DW = dpls_pkg::PERIOD_W;
	localparam int CNT_W = $clog2(QW + 1);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0] part_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quot_q;
	logic [DW:0] shifted;
	logic [DW:0] diff;
	logic ge;

	assign shifted = {part_q, quot_q[QW-1]};
	assign ge = shifted >= {1'b0, den_q};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			part_q <= dividend[dpls_pkg::PROD_W-1:QW];
			quot_q <= dividend[QW-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			part_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quotient = quot_q;

endmodule

### hw/rtl/dpls_dp.sv
// datapath: config registers, pattern state, line walk registers, segment buffer, output stage
module dpls_dp #(
	parameter int PATTERN_PAIRS = dpls_pkg::PATTERN_PAIRS_DEF,
	parameter int MAX_SEGMENTS = dpls_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dpls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dpls_pkg::CFG_W-1:0]           cfg_data,
	input  logic signed [dpls_pkg::COORD_W-1:0]  point_x,
	input  logic signed [dpls_pkg::COORD_W-1:0]  point_y,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic signed [dpls_pkg::COORD_W-1:0]  seg_start_x,
	output logic signed [dpls_pkg::COORD_W-1:0]  seg_start_y,
	output logic signed [dpls_pkg::COORD_W-1:0]  seg_end_x,
	output logic signed [dpls_pkg::COORD_W-1:0]  seg_end_y,
	output logic                                 last_segment,
	output logic                                 overflow,
	input  dpls_pkg::dp_cmd_t                    ctl,
	output dpls_pkg::dp_stat_t                   stat
);

	localparam int CW = dpls_pkg::COORD_W;
	localparam int LW = dpls_pkg::LEN_W;
	localparam int PW = dpls_pkg::PERIOD_W;
	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int NW = $clog2(MAX_SEGMENTS + 1);

	logic [1:0] pcount_q;
	dpls_pkg::len_tab_t dash_q, gap_q;
	logic [PW-1:0] period_q;
	logic [1:0] used, nxt_idx;

	logic [1:0] pidx_q;
	logic [LW-1:0] rem_q;
	logic in_gap_q;
	logic [CW-1:0] start_x_q, start_y_q, cur_x_q, cur_y_q;
	logic [CW-1:0] tx_q, ty_q, x1_q, y1_q, px_q, py_q, nx_q, ny_q;
	logic [CW-1:0] ax_q, ay_q;
	logic negx_q, negy_q;
	logic [LW-1:0] total_q, left_q, dist_q, dtgt_q;
	logic walked_q, ovf_q;
	logic [NW-1:0] res_n_q, rd_ptr_q;
	logic [dpls_pkg::PROD_W-1:0] prod_q;

	logic [CW-1:0] tgt_x, tgt_y;
	logic [CW:0] dx, dy, mag_x, mag_y;
	logic [CW-1:0] mx, mn;
	logic [CW+1:0] tri_mn;
	logic [LW-1:0] tot;
	logic [LW-1:0] tail_rem;
	logic [LW-1:0] kp;
	logic [PW-1:0] mul_a;
	logic [LW-1:0] mul_b;
	logic [CW-1:0] q_lo, x_sel, ex, ey;
	logic neg_sel;
	logic [CW-1:0] interp_res;

	logic div_start, div_busy;
	logic [dpls_pkg::PROD_W-1:0] div_num;
	logic [PW-1:0] div_den;
	logic [dpls_pkg::QUOT_W-1:0] quot;

	logic emit_now, mem_we, seg_full, load;
	logic [4*CW-1:0] mem [MAX_SEGMENTS];
	logic [4*CW-1:0] rdata_q;
	logic out_valid_q, last_q, ovf_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= 2'd1;
			dash_q <= {3{dpls_pkg::LEN_RESET}};
			gap_q <= {3{dpls_pkg::LEN_RESET}};
		end else if (cfg_we) begin
			case (cfg_index)
				dpls_pkg::REG_PATTERN_COUNT: pcount_q <= cfg_data[1:0];
				dpls_pkg::REG_DASH_A: dash_q[0] <= cfg_data;
				dpls_pkg::REG_GAP_A: gap_q[0] <= cfg_data;
				dpls_pkg::REG_DASH_B: dash_q[1] <= cfg_data;
				dpls_pkg::REG_GAP_B: gap_q[1] <= cfg_data;
				dpls_pkg::REG_DASH_C: dash_q[2] <= cfg_data;
				dpls_pkg::REG_GAP_C: gap_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// period only changes with config, so a registered copy is always current when walking
	always_ff @(posedge clk) begin
		period_q <= dpls_pkg::period_len(pcount_q, dash_q, gap_q, PATTERN_PAIRS);
	end

	assign used = dpls_pkg::pairs_used(pcount_q, PATTERN_PAIRS);
	assign nxt_idx = dpls_pkg::next_index(pidx_q, used);

	always_comb begin
		tgt_x = ctl.use_start ? start_x_q : point_x;
		tgt_y = ctl.use_start ? start_y_q : point_y;
		dx = {tgt_x[CW-1], tgt_x} - {cur_x_q[CW-1], cur_x_q};
		dy = {tgt_y[CW-1], tgt_y} - {cur_y_q[CW-1], cur_y_q};
		mag_x = dx[CW] ? (~dx + (CW+1)'(1)) : dx;
		mag_y = dy[CW] ? (~dy + (CW+1)'(1)) : dy;
		mx = (ax_q > ay_q) ? ax_q : ay_q;
		mn = (ax_q > ay_q) ? ay_q : ax_q;
		tri_mn = {2'b00, mn} + {1'b0, mn, 1'b0};
		tot = {1'b0, mx} + LW'(tri_mn >> 3);
		tail_rem = rem_q - left_q;
		kp = prod_q[LW-1:0];
		mul_a = (ctl.op == dpls_pkg::OP_MUL_KP) ? period_q : PW'(ctl.axis_y ? ay_q : ax_q);
		mul_b = (ctl.op == dpls_pkg::OP_MUL_KP) ? quot : dtgt_q;
		q_lo = quot[CW-1:0];
		x_sel = ctl.axis_y ? y1_q : x1_q;
		neg_sel = ctl.axis_y ? negy_q : negx_q;
		interp_res = neg_sel ? (x_sel - q_lo) : (x_sel + q_lo);
		ex = (ctl.op == dpls_pkg::OP_EMIT_CUT) ? nx_q : tx_q;
		ey = (ctl.op == dpls_pkg::OP_EMIT_CUT) ? ny_q : ty_q;
	end

	assign div_start = (ctl.op == dpls_pkg::OP_SKIP_DIV) || (ctl.op == dpls_pkg::OP_DIV_INTERP);
	assign div_num = (ctl.op == dpls_pkg::OP_SKIP_DIV) ?
		dpls_pkg::PROD_W'(left_q - LW'(1)) : prod_q;
	assign div_den = (ctl.op == dpls_pkg::OP_SKIP_DIV) ? period_q : PW'(total_q);

	dpls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (quot)
	);

	assign seg_full = res_n_q >= NW'(MAX_SEGMENTS);
	assign emit_now = ((ctl.op == dpls_pkg::OP_EMIT_TAIL) || (ctl.op == dpls_pkg::OP_EMIT_CUT))
		&& !in_gap_q;
	assign mem_we = emit_now && !seg_full;
	assign load = (ctl.op == dpls_pkg::OP_DRAIN) && (rd_ptr_q != res_n_q)
		&& (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pidx_q <= '0;
			rem_q <= '0;
			in_gap_q <= 1'b0;
			start_x_q <= '0;
			start_y_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			walked_q <= 1'b0;
			ovf_q <= 1'b0;
			res_n_q <= '0;
			rd_ptr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (load) rd_ptr_q <= rd_ptr_q + NW'(1);
			if (emit_now) begin
				if (seg_full) ovf_q <= 1'b1;
				else res_n_q <= res_n_q + NW'(1);
			end
			case (ctl.op)
				dpls_pkg::OP_MOVE: begin
					pidx_q <= '0;
					rem_q <= LW'(dpls_pkg::dash_of(2'd0, dash_q, PATTERN_PAIRS));
					in_gap_q <= 1'b0;
					start_x_q <= point_x;
					start_y_q <= point_y;
					cur_x_q <= point_x;
					cur_y_q <= point_y;
				end
				dpls_pkg::OP_LINE_INIT: begin
					walked_q <= 1'b0;
					ovf_q <= 1'b0;
					res_n_q <= '0;
					rd_ptr_q <= '0;
				end
				dpls_pkg::OP_SHORT_END: begin
					rem_q <= tail_rem;
					cur_x_q <= tx_q;
					cur_y_q <= ty_q;
				end
				dpls_pkg::OP_TAIL_END: begin
					cur_x_q <= tx_q;
					cur_y_q <= ty_q;
					if (tail_rem < dpls_pkg::LEN_ONE) begin
						// less than one unit left: step to the next phase
						if (!in_gap_q) begin
							in_gap_q <= 1'b1;
							rem_q <= LW'(dpls_pkg::gap_of(pidx_q, gap_q, PATTERN_PAIRS));
						end else begin
							in_gap_q <= 1'b0;
							pidx_q <= nxt_idx;
							rem_q <= LW'(dpls_pkg::dash_of(nxt_idx, dash_q, PATTERN_PAIRS));
						end
					end else begin
						rem_q <= tail_rem;
					end
				end
				dpls_pkg::OP_SKIP_APPLY: ovf_q <= 1'b1;
				dpls_pkg::OP_CUT_APPLY: begin
					walked_q <= 1'b1;
					in_gap_q <= !in_gap_q;
					if (!in_gap_q) begin
						rem_q <= LW'(dpls_pkg::gap_of(pidx_q, gap_q, PATTERN_PAIRS));
					end else begin
						pidx_q <= nxt_idx;
						rem_q <= LW'(dpls_pkg::dash_of(nxt_idx, dash_q, PATTERN_PAIRS));
					end
				end
				default: ;
			endcase
		end
	end

	// walk registers, no reset needed
	always_ff @(posedge clk) begin
		case (ctl.op)
			dpls_pkg::OP_LINE_INIT: begin
				tx_q <= tgt_x;
				ty_q <= tgt_y;
				x1_q <= cur_x_q;
				y1_q <= cur_y_q;
				px_q <= cur_x_q;
				py_q <= cur_y_q;
				ax_q <= mag_x[CW-1:0];
				ay_q <= mag_y[CW-1:0];
				negx_q <= dx[CW];
				negy_q <= dy[CW];
				dist_q <= '0;
			end
			dpls_pkg::OP_TOTAL: begin
				total_q <= tot;
				left_q <= tot;
			end
			dpls_pkg::OP_MUL_KP, dpls_pkg::OP_MUL_INTERP: prod_q <= mul_a * mul_b;
			dpls_pkg::OP_SKIP_APPLY: begin
				left_q <= left_q - kp;
				dist_q <= dist_q + kp;
				dtgt_q <= dist_q + kp;
			end
			dpls_pkg::OP_SET_ND: dtgt_q <= dist_q + rem_q;
			dpls_pkg::OP_STORE: begin
				if (ctl.axis_y) ny_q <= interp_res;
				else nx_q <= interp_res;
			end
			dpls_pkg::OP_CUT_APPLY: begin
				left_q <= left_q - rem_q;
				dist_q <= dtgt_q;
				px_q <= nx_q;
				py_q <= ny_q;
			end
			dpls_pkg::OP_TAKE_N: begin
				px_q <= nx_q;
				py_q <= ny_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[res_n_q[AW-1:0]] <= {px_q, py_q, ex, ey};
		if (load) begin
			rdata_q <= mem[rd_ptr_q[AW-1:0]];
			last_q <= (rd_ptr_q + NW'(1)) == res_n_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign stat.short_line = left_q < rem_q;
	assign stat.loop_go = left_q > rem_q;
	assign stat.skip_ok = walked_q && seg_full && (pidx_q < used) && (PW'(left_q) > period_q);
	assign stat.div_busy = div_busy;
	assign stat.drain_done = rd_ptr_q == res_n_q;

	assign out_valid = out_valid_q;
	assign seg_start_x = rdata_q[4*CW-1:3*CW];
	assign seg_start_y = rdata_q[3*CW-1:2*CW];
	assign seg_end_x = rdata_q[2*CW-1:CW];
	assign seg_end_y = rdata_q[CW-1:0];
	assign last_segment = last_q;
	assign overflow = ovf_out_q;

endmodule

### hw/rtl/dpls_ctrl.sv
// controller: sequences the line walk, the shared divider and the result drain
module dpls_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          cmd,
	output logic                in_ready,
	output dpls_pkg::dp_cmd_t   ctl,
	input  dpls_pkg::dp_stat_t  stat
);

	typedef enum logic [4:0] {
		S_IDLE, S_TOTAL, S_CHECK, S_SHORT_EMIT, S_SHORT_END, S_LOOP, S_TAIL_EMIT,
		S_TAIL_END, S_SKIP_DIV, S_SKIP_WAIT, S_SKIP_MUL, S_SKIP_APPLY, S_SET_ND,
		S_MUL_X, S_DIV_X, S_WAIT_X, S_STORE_X, S_MUL_Y, S_DIV_Y, S_WAIT_Y, S_STORE_Y,
		S_TAKE_N, S_EMIT_CUT, S_CUT_APPLY, S_DRAIN
	} state_t;

	state_t state_q;
	logic skip_q;

	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			skip_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && (cmd == dpls_pkg::CMD_LINE || cmd == dpls_pkg::CMD_CLOSE)) begin
						state_q <= S_TOTAL;
					end
				end
				S_TOTAL: state_q <= S_CHECK;
				S_CHECK: state_q <= stat.short_line ? S_SHORT_EMIT : S_LOOP;
				S_SHORT_EMIT: state_q <= S_SHORT_END;
				S_SHORT_END: state_q <= S_DRAIN;
				S_LOOP: begin
					if (!stat.loop_go) begin
						state_q <= S_TAIL_EMIT;
					end else if (stat.skip_ok) begin
						// past the cap: jump whole periods at once
						skip_q <= 1'b1;
						state_q <= S_SKIP_DIV;
					end else begin
						skip_q <= 1'b0;
						state_q <= S_SET_ND;
					end
				end
				S_TAIL_EMIT: state_q <= S_TAIL_END;
				S_TAIL_END: state_q <= S_DRAIN;
				S_SKIP_DIV: state_q <= S_SKIP_WAIT;
				S_SKIP_WAIT: if (!stat.div_busy) state_q <= S_SKIP_MUL;
				S_SKIP_MUL: state_q <= S_SKIP_APPLY;
				S_SKIP_APPLY: state_q <= S_MUL_X;
				S_SET_ND: state_q <= S_MUL_X;
				S_MUL_X: state_q <= S_DIV_X;
				S_DIV_X: state_q <= S_WAIT_X;
				S_WAIT_X: if (!stat.div_busy) state_q <= S_STORE_X;
				S_STORE_X: state_q <= S_MUL_Y;
				S_MUL_Y: state_q <= S_DIV_Y;
				S_DIV_Y: state_q <= S_WAIT_Y;
				S_WAIT_Y: if (!stat.div_busy) state_q <= S_STORE_Y;
				S_STORE_Y: state_q <= skip_q ? S_TAKE_N : S_EMIT_CUT;
				S_TAKE_N: state_q <= S_LOOP;
				S_EMIT_CUT: state_q <= S_CUT_APPLY;
				S_CUT_APPLY: state_q <= S_LOOP;
				S_DRAIN: if (stat.drain_done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.op = dpls_pkg::OP_IDLE;
		ctl.use_start = cmd == dpls_pkg::CMD_CLOSE;
		ctl.axis_y = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && cmd == dpls_pkg::CMD_MOVE) ctl.op = dpls_pkg::OP_MOVE;
				else if (in_valid && (cmd == dpls_pkg::CMD_LINE || cmd == dpls_pkg::CMD_CLOSE))
					ctl.op = dpls_pkg::OP_LINE_INIT;
			end
			S_TOTAL: ctl.op = dpls_pkg::OP_TOTAL;
			S_SHORT_EMIT, S_TAIL_EMIT: ctl.op = dpls_pkg::OP_EMIT_TAIL;
			S_SHORT_END: ctl.op = dpls_pkg::OP_SHORT_END;
			S_TAIL_END: ctl.op = dpls_pkg::OP_TAIL_END;
			S_SKIP_DIV: ctl.op = dpls_pkg::OP_SKIP_DIV;
			S_SKIP_MUL: ctl.op = dpls_pkg::OP_MUL_KP;
			S_SKIP_APPLY: ctl.op = dpls_pkg::OP_SKIP_APPLY;
			S_SET_ND: ctl.op = dpls_pkg::OP_SET_ND;
			S_MUL_X: ctl.op = dpls_pkg::OP_MUL_INTERP;
			S_DIV_X: ctl.op = dpls_pkg::OP_DIV_INTERP;
			S_STORE_X: ctl.op = dpls_pkg::OP_STORE;
			S_MUL_Y: begin
				ctl.op = dpls_pkg::OP_MUL_INTERP;
				ctl.axis_y = 1'b1;
			end
			S_DIV_Y: ctl.op = dpls_pkg::OP_DIV_INTERP;
			S_STORE_Y: begin
				ctl.op = dpls_pkg::OP_STORE;
				ctl.axis_y = 1'b1;
			end
			S_TAKE_N: ctl.op = dpls_pkg::OP_TAKE_N;
			S_EMIT_CUT: ctl.op = dpls_pkg::OP_EMIT_CUT;
			S_CUT_APPLY: ctl.op = dpls_pkg::OP_CUT_APPLY;
			S_DRAIN: ctl.op = dpls_pkg::OP_DRAIN;
			default: ctl.op = dpls_pkg::OP_IDLE;
		endcase
	end

endmodule

### hw/rtl/dash_pattern_line_splitter_unit.sv
// top level of the dash pattern line splitter
// Cuts move/line/close path commands (signed 18.6 coordinates) at the boundaries of a
// repeating dash pattern of up to three dash/gap pairs and returns the dash-on pieces as
// segments, at most MAX_SEGMENTS per request, with last_segment on the final one and
// overflow on all of them when pieces past the cap were dropped. One request is worked at a
// time. A move is taken in the idle state and an unknown command is ignored. For a line or
// close, the shared divider finds each cut point (x then y) at every dash or gap boundary it
// crosses; beyond the cap, whole periods are skipped in one step. Segments are buffered and
// then delivered one per cycle while out_ready is high, so a request holds the input until
// every one of its results has left the buffer. Configuration takes effect on the next
// request only if written between requests; the block itself does not enforce this.
module dash_pattern_line_splitter_unit #(
	parameter int PATTERN_PAIRS = dpls_pkg::PATTERN_PAIRS_DEF,
	parameter int MAX_SEGMENTS = dpls_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dpls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dpls_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           cmd,
	input  logic signed [dpls_pkg::COORD_W-1:0]  point_x,
	input  logic signed [dpls_pkg::COORD_W-1:0]  point_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [dpls_pkg::COORD_W-1:0]  seg_start_x,
	output logic signed [dpls_pkg::COORD_W-1:0]  seg_start_y,
	output logic signed [dpls_pkg::COORD_W-1:0]  seg_end_x,
	output logic signed [dpls_pkg::COORD_W-1:0]  seg_end_y,
	output logic                                 last_segment,
	output logic                                 overflow
);

	dpls_pkg::dp_cmd_t ctl;
	dpls_pkg::dp_stat_t stat;

	dpls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_ready (in_ready),
		.ctl      (ctl),
		.stat     (stat)
	);

	dpls_dp #(
		.PATTERN_PAIRS (PATTERN_PAIRS),
		.MAX_SEGMENTS  (MAX_SEGMENTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.point_x      (point_x),
		.point_y      (point_y),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.seg_start_x  (seg_start_x),
		.seg_start_y  (seg_start_y),
		.seg_end_x    (seg_end_x),
		.seg_end_y    (seg_end_y),
		.last_segment (last_segment),
		.overflow     (overflow),
		.ctl          (ctl),
		.stat         (stat)
	);

endmodule

### hw/rtl/dpls_checker.sv
// port-level checker for the dash line splitter and its bind
module dpls_checker #(
	parameter int MAX_SEGMENTS = dpls_pkg::MAX_SEGMENTS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [dpls_pkg::COORD_W-1:0]  seg_start_x,
	input logic signed [dpls_pkg::COORD_W-1:0]  seg_start_y,
	input logic signed [dpls_pkg::COORD_W-1:0]  seg_end_x,
	input logic signed [dpls_pkg::COORD_W-1:0]  seg_end_y,
	input logic                                 last_segment,
	input logic                                 overflow
);

	localparam int NW = $clog2(MAX_SEGMENTS + 1);

	logic acc;
	logic [NW-1:0] cnt_q;
	logic ovf_prev_q;

	assign acc = out_valid && out_ready;

	// results already delivered for the request in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_prev_q <= 1'b0;
		end else if (acc) begin
			cnt_q <= last_segment ? '0 : cnt_q + NW'(1);
			ovf_prev_q <= overflow;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(seg_start_x) && $stable(seg_start_y)
			&& $stable(seg_end_x) && $stable(seg_end_y) && $stable(last_segment)
			&& $stable(overflow))
		else $error("result changed while stalled");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> cnt_q < NW'(MAX_SEGMENTS))
		else $error("more results than the cap for one request");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		acc && overflow && last_segment |-> cnt_q == NW'(MAX_SEGMENTS - 1))
		else $error("overflow flagged on a request below the cap");

	a_ovf_same: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cnt_q != '0 |-> overflow == ovf_prev_q)
		else $error("overflow flag differs within one request");

endmodule

bind dash_pattern_line_splitter_unit dpls_checker #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dpls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.seg_start_x  (seg_start_x),
	.seg_start_y  (seg_start_y),
	.seg_end_x    (seg_end_x),
	.seg_end_y    (seg_end_y),
	.last_segment (last_segment),
	.overflow     (overflow)
);
